### rtl/core/phsu_pkg.sv
// ----------------------------------------------------------------------------
// phsu_pkg
// shared types and constants of the protocol history stack update core
// ----------------------------------------------------------------------------
package phsu_pkg;

  localparam int HIST_DEPTH  = 4;
  localparam int CNT_W       = $clog2(HIST_DEPTH + 1);
  localparam int IDX_W       = $clog2(HIST_DEPTH);
  localparam int ID_W        = 16;
  localparam int SLOT_W      = 4;
  localparam int DEPTH_W     = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_PUSH,
    OP_INSERT
  } op_e;

  typedef struct packed {
    logic [ID_W-1:0] protocol_id;
    logic            is_correlated;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_index;
    logic [ID_W-1:0]    slot_protocol;
    logic               slot_is_real;
    logic [DEPTH_W-1:0] stack_depth;
    logic               last_slot;
  } out_t;

  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] id;
  } cmd_t;

endpackage

### rtl/core/phsu_front.sv
// ----------------------------------------------------------------------------
// phsu_front
// accepts input transactions, classifies them and queues the commands
// ----------------------------------------------------------------------------
module phsu_front import phsu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  in_t   in_data_i,
  output logic  cmd_valid_o,
  input  logic  cmd_pop_i,
  output cmd_t  cmd_o
);

  cmd_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;
  logic              pop;
  cmd_t              cmd_new;

  assign in_stall_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    cmd_new.op = in_data_i.is_correlated ? OP_PUSH : OP_INSERT;
    cmd_new.id = in_data_i.protocol_id;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

### rtl/core/phsu_back.sv
// ----------------------------------------------------------------------------
// phsu_back
// applies queued commands to the history stack and emits the stack slots
// ----------------------------------------------------------------------------
module phsu_back import phsu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ID_W-1:0] unknown_code_i,
  input  logic            cmd_valid_i,
  output logic            cmd_pop_o,
  input  cmd_t            cmd_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_t            out_data_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                  state_q, state_d;
  logic [ID_W-1:0]       stack_q [HIST_DEPTH];
  logic [ID_W-1:0]       stack_d [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] marks_q, marks_d;
  logic [CNT_W-1:0]      size_q, size_d;
  logic [IDX_W-1:0]      slot_q, slot_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  logic [CNT_W-1:0]      first_real;
  logic [CNT_W-1:0]      at_cnt;
  logic [IDX_W-1:0]      at;
  logic [CNT_W-1:0]      size_m1;
  logic                  full;
  logic                  restore;
  logic                  out_load;
  logic                  last_load;
  logic                  pop;

  assign size_m1 = size_q - 1'b1;
  assign full    = (size_q == CNT_W'(HIST_DEPTH));

  // topmost real slot, or the depth if none
  always_comb begin
    first_real = size_q;
    for (int i = HIST_DEPTH - 1; i >= 0; i--) begin
      if (marks_q[i]) begin
        first_real = CNT_W'(i);
      end
    end
  end

  assign at_cnt  = (first_real >= size_q) ? size_m1 : first_real;
  assign at      = at_cnt[IDX_W-1:0];
  assign restore = full && (first_real == CNT_W'(HIST_DEPTH - 1)) &&
                   (stack_q[HIST_DEPTH-1] != unknown_code_i);

  // stack update
  always_comb begin
    for (int a = 0; a < HIST_DEPTH; a++) begin
      stack_d[a] = stack_q[a];
    end
    marks_d = marks_q;
    size_d  = full ? size_q : size_q + 1'b1;
    if (cmd_i.op == OP_PUSH) begin
      for (int a = 1; a < HIST_DEPTH; a++) begin
        stack_d[a] = stack_q[a-1];
      end
      stack_d[0] = cmd_i.id;
      marks_d    = {marks_q[HIST_DEPTH-2:0], 1'b0};
      if (restore) begin
        stack_d[HIST_DEPTH-1] = stack_q[HIST_DEPTH-1];
        marks_d[HIST_DEPTH-1] = 1'b1;
      end
    end else begin
      for (int a = 1; a < HIST_DEPTH; a++) begin
        if (IDX_W'(a) > at) begin
          stack_d[a] = stack_q[a-1];
          marks_d[a] = marks_q[a-1];
        end
      end
      stack_d[at] = cmd_i.id;
      marks_d[at] = 1'b1;
    end
    for (int a = 0; a < HIST_DEPTH; a++) begin
      if (CNT_W'(a) >= size_d) begin
        marks_d[a] = 1'b0;
      end
    end
  end

  // slot emission through the output register
  assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign last_load = out_load && (slot_q == size_m1[IDX_W-1:0]);
  assign pop       = cmd_valid_i && ((state_q == ST_IDLE) || last_load);
  assign cmd_pop_o = pop;

  always_comb begin
    out_d.slot_index    = SLOT_W'(slot_q);
    out_d.slot_protocol = stack_q[slot_q];
    out_d.slot_is_real  = marks_q[slot_q];
    out_d.stack_depth   = DEPTH_W'(size_q);
    out_d.last_slot     = (slot_q == size_m1[IDX_W-1:0]);
  end

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load && !last_load) begin
      slot_d = slot_q + 1'b1;
    end
    if (pop) begin
      state_d = ST_EMIT;
      slot_d  = '0;
    end else if (last_load) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      marks_q     <= '0;
      size_q      <= CNT_W'(1);
      for (int a = 0; a < HIST_DEPTH; a++) begin
        stack_q[a] <= '0;
      end
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      if (pop) begin
        marks_q <= marks_d;
        size_q  <= size_d;
        for (int a = 0; a < HIST_DEPTH; a++) begin
          stack_q[a] <= stack_d[a];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/protocol_history_stack_update_core.sv
// ----------------------------------------------------------------------------
// protocol_history_stack_update_core
// bounded protocol history stack of one flow with per-slot real marks
// ----------------------------------------------------------------------------
// Each input transaction carries a protocol id and a correlated flag and
// updates the stack; the whole stack is then emitted top to bottom, one
// output transaction per slot, last_slot set on the bottom one. After an
// update the stack holds 2 to HIST_DEPTH slots; the single slot emission
// port sends them one after another, and the back end takes the next
// command with the last slot of an item or when it is idle. A two-entry
// command queue lets the input keep accepting while slots are being emitted.
// unknown_code is written through the cfg port, which is always ready.
module protocol_history_stack_update_core import phsu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_t             in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_t            out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [ID_W-1:0] cfg_data_i
);

  logic [ID_W-1:0] unknown_code_q;
  logic            cmd_valid;
  logic            cmd_pop;
  cmd_t            cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unknown_code_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unknown_code_q <= cfg_data_i;
    end
  end

  phsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  phsu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .unknown_code_i (unknown_code_q),
    .cmd_valid_i    (cmd_valid),
    .cmd_pop_o      (cmd_pop),
    .cmd_i          (cmd),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

### rtl/core/phsu_checker.sv
// ----------------------------------------------------------------------------
// phsu_checker
// port-level checks of the protocol history stack update core
// ----------------------------------------------------------------------------
module phsu_checker import phsu_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input out_t            out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.stack_depth != '0) &&
                    (out_data_o.stack_depth <= DEPTH_W'(HIST_DEPTH)) &&
                    ({1'b0, out_data_o.slot_index} < out_data_o.stack_depth))
    else $error("slot outside stack depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.last_slot ==
                    ({1'b0, out_data_o.slot_index} == out_data_o.stack_depth - 1'b1))
    else $error("last slot flag mismatch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_slot |=>
      out_valid_o && (out_data_o.slot_index == $past(out_data_o.slot_index) + 1'b1) &&
      (out_data_o.stack_depth == $past(out_data_o.stack_depth)))
    else $error("slot run broken");

endmodule

bind protocol_history_stack_update_core phsu_checker u_phsu_checker (.*);

### test/protocol_history_stack_update_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// protocol_history_stack_update_core_test
// self-checking bench for the protocol history stack update core
// ----------------------------------------------------------------------------
// Drives protocol ids, both correlated and real, through the input channel
// and predicts the full stack dump that each update produces. Every slot
// transaction is compared field by field against the oldest prediction. The
// unknown code register is rewritten between phases while the core is idle.
// Both channels idle and stall at random; one phase runs without gaps and
// one holds the output off long enough to back the input up.
module protocol_history_stack_update_core_test;
  import phsu_pkg::*;

  localparam int LIMIT = 200000;

  class history_scoreboard;
    logic [ID_W-1:0]       hist [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] marks;
    logic [3:0]            depth_m1;
    logic [ID_W-1:0]       unknown;
    out_t                  expected_slots [$];
    int                    errors;
    int                    items;
    int                    checked;
    int                    restores;
    int                    skipped;

    function new();
      foreach (hist[i]) hist[i] = '0;
      marks    = '0;
      depth_m1 = '0;
      unknown  = '0;
      errors   = 0;
      items    = 0;
      checked  = 0;
      restores = 0;
      skipped  = 0;
    endfunction

    function void set_unknown(logic [ID_W-1:0] code);
      unknown = code;
    endfunction

    function int top_real(logic [HIST_DEPTH-1:0] m, int n);
      int i;
      for (i = 0; i < n; i++) begin
        if (m[i]) return i;
      end
      return n;
    endfunction

    // apply one update to the stack and queue the dump it causes
    function void note_update(in_t item);
      int                  size;
      int                  at;
      int                  a;
      int                  k;
      logic                restore;
      logic [ID_W-1:0]     saved;
      logic [HIST_DEPTH:0] m;
      logic [HIST_DEPTH:0] keep;
      out_t                slot;
      items++;
      size = int'(depth_m1) + 1;
      if (size > HIST_DEPTH) size = HIST_DEPTH;
      m       = {1'b0, marks};
      restore = 1'b0;
      saved   = '0;
      if (item.is_correlated) begin
        if (size == HIST_DEPTH) begin
          if (top_real(marks, size) == size - 1) begin
            saved   = hist[size-1];
            restore = (saved != unknown);
            if (restore) restores++;
            else skipped++;
          end
        end else begin
          size++;
        end
        for (a = size - 1; a > 0; a--) hist[a] = hist[a-1];
        m       = m << 1;
        hist[0] = item.protocol_id;
        if (restore) begin
          hist[size-1] = saved;
          m[size-1]    = 1'b1;
        end
      end else begin
        at = 0;
        if (!marks[0]) at = top_real(marks, size);
        if (at >= size) at = size - 1;
        if (size < HIST_DEPTH) size++;
        for (a = size - 1; a > at; a--) hist[a] = hist[a-1];
        keep     = (HIST_DEPTH+1)'((1 << at) - 1);
        m        = ((m & ~keep) << 1) | (m & keep);
        hist[at] = item.protocol_id;
        m[at]    = 1'b1;
      end
      keep     = (HIST_DEPTH+1)'((1 << size) - 1);
      m        = m & keep;
      marks    = m[HIST_DEPTH-1:0];
      depth_m1 = 4'(size - 1);
      for (k = 0; k < size; k++) begin
        slot.slot_index    = SLOT_W'(k);
        slot.slot_protocol = hist[k];
        slot.slot_is_real  = marks[k];
        slot.stack_depth   = DEPTH_W'(size);
        slot.last_slot     = (k == size - 1);
        expected_slots.push_back(slot);
      end
    endfunction

    function void compare(string field, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 20)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_slot(out_t got);
      out_t want;
      if (expected_slots.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: slot transaction with nothing expected, expected none, actual %h",
                   $time, got);
        return;
      end
      want = expected_slots.pop_front();
      checked++;
      compare("slot_index", ID_W'(want.slot_index), ID_W'(got.slot_index));
      compare("slot_protocol", want.slot_protocol, got.slot_protocol);
      compare("slot_is_real", ID_W'(want.slot_is_real), ID_W'(got.slot_is_real));
      compare("stack_depth", ID_W'(want.stack_depth), ID_W'(got.stack_depth));
      compare("last_slot", ID_W'(want.last_slot), ID_W'(got.last_slot));
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction
  endclass

  logic            clk;
  logic            rst_ni;
  logic            in_valid;
  logic            in_stall;
  in_t             in_data;
  logic            out_valid;
  logic            out_stall;
  out_t            out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [ID_W-1:0] cfg_data;

  history_scoreboard sb;
  logic              gaps_on;
  logic              hold_req;
  logic              hold_off;
  int                cycles;

  protocol_history_stack_update_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("protocol_history_stack_update_core_test NOT OK");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      out_stall <= hold_off || (gaps_on && $urandom_range(99) < 35);
    end
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) sb.check_slot(out_data);
  end

  task automatic send(logic [ID_W-1:0] id, logic corr);
    in_t item;
    item.protocol_id   = id;
    item.is_correlated = corr;
    while (gaps_on && $urandom_range(99) < 35) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_update(item);
  endtask

  task automatic write_unknown(logic [ID_W-1:0] code);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_unknown(code);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic finish_phase();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_id(logic [ID_W-1:0] code);
    case ($urandom_range(3))
      0:       return code;
      1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return ID_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [ID_W-1:0] code;
    sb        = new();
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    gaps_on   = 1'b1;
    hold_req  = 1'b0;
    hold_off  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // directed: fill from reset, bottom kept, unknown bottom dropped
    write_unknown(16'h0000);
    send(16'hFFFF, 1'b0);
    send(16'h8000, 1'b0);
    send(16'h0000, 1'b1);
    send(16'h1234, 1'b1);
    send(16'hABCD, 1'b1);
    send(16'h5555, 1'b1);
    send(16'hAAAA, 1'b1);
    send(16'h0001, 1'b0);
    send(16'h0000, 1'b0);
    send(16'h7777, 1'b1);
    send(16'h8888, 1'b1);
    send(16'hFFFE, 1'b0);
    send(16'h4321, 1'b0);
    finish_phase();

    write_unknown(16'hFFFF);
    send(16'h0000, 1'b1);
    send(16'hFFFF, 1'b0);
    send(16'h0001, 1'b1);
    send(16'h1111, 1'b0);
    send(16'h2222, 1'b0);
    send(16'h3333, 1'b1);
    finish_phase();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       code = 16'h0000;
        1:       code = 16'hFFFF;
        2:       code = 16'h00A5;
        3:       code = ID_W'($urandom());
        default: code = 16'h8001;
      endcase
      gaps_on = (ph != 1);
      if (ph == 2) hold_req = 1'b1;
      write_unknown(code);
      repeat (40) send(pick_id(code), 1'($urandom_range(1)));
      finish_phase();
    end

    $display("run covered %0d stack updates and %0d slot transactions",
             sb.items, sb.checked);
    $display("bottom entry kept %0d times, dropped as unknown %0d times",
             sb.restores, sb.skipped);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("protocol_history_stack_update_core_test OK");
    end else begin
      $display("protocol_history_stack_update_core_test NOT OK");
    end
    $finish;
  end

endmodule
